>>> design/bae_pkg.sv
// Package for the button autorepeat event block: sizes, register map,
// reset values and tick scaling. No dependencies.
`timescale 1ns / 1ps

package bae_pkg;

  // Logical buttons scanned per poll (default of the top-level parameter).
  localparam int NumButtonsDef = 14;
  // Width of the button masks carried by a poll item.
  localparam int MaskW = 14;
  // Ticks per millisecond of the system tick.
  localparam int TicksPerMs = 19200;
  // Largest delay in ticks: 65535 ms * 19200 fits in 31 bits.
  localparam int DelayTickW = 31;
  // Most events that one poll may report.
  localparam logic [3:0] ResultLimit = 4'd14;

  // APB register map, byte address 4*index.
  localparam int PaddrW = 4;
  localparam logic [1:0] RegFirstDelay  = 2'd0;
  localparam logic [1:0] RegRepeatIntvl = 2'd1;
  localparam logic [1:0] RegMaxEvents   = 2'd2;

  localparam logic [15:0] FirstDelayRst  = 16'd500;
  localparam logic [15:0] RepeatIntvlRst = 16'd100;
  localparam logic [3:0]  MaxEventsRst   = 4'd14;

  // Scale a delay in milliseconds to ticks.
  function automatic logic [DelayTickW-1:0] ms_to_ticks(input logic [15:0] ms);
    logic [DelayTickW-1:0] prod;
    prod = DelayTickW'(ms) * DelayTickW'(TicksPerMs);
    return prod;
  endfunction

endpackage

>>> design/bae_intf.sv
// Handshake channels of the button autorepeat event block: the poll input
// and the event output. Depends on bae_pkg for the mask width.
`timescale 1ns / 1ps

interface bae_poll_if;
  logic                     valid;
  logic                     ready;
  logic [bae_pkg::MaskW-1:0] pressed_now;
  logic [bae_pkg::MaskW-1:0] held_now;
  logic [63:0]              tick_now;

  modport source (output valid, output pressed_now, output held_now, output tick_now,
                  input ready);
  modport sink   (input valid, input pressed_now, input held_now, input tick_now,
                  output ready);
endinterface

interface bae_evt_if;
  logic       valid;
  logic       ready;
  logic [3:0] button_event;
  logic       event_valid;
  logic       last;

  modport source (output valid, output button_event, output event_valid, output last,
                  input ready);
  modport sink   (input valid, input button_event, input event_valid, input last,
                  output ready);
endinterface

>>> design/button_autorepeat_events_top.sv
// Button autorepeat event generator, top level.
// Depends on bae_pkg and the channel interfaces in bae_intf.sv.
`timescale 1ns / 1ps

// One poll item carries the newly-pressed mask, the held mask and the current
// 64-bit tick. The block walks the buttons from index 0 up, one button per
// cycle, through a per-button state memory with one read and one write port
// (hold start tick and repeating flag, registered read data): each cycle it
// reads the next button while it updates and writes back the previous one. A
// new press fires and restarts the timer, a held button fires after
// first_delay_ms and then every repeat_interval_ms (both scaled by 19200
// ticks per ms, elapsed time taken modulo 2^64), a released button has its
// state cleared. Fired buttons below the per-poll cap are collected in a mask
// and then delivered as event items in index order, the final one flagged
// last; a poll that fires nothing yields one item with event_valid low and
// last high. A poll is accepted, then scanned over every button plus the
// registered memory read, then delivered as its items (at least one), which
// a stalled output holds back; the next poll is taken once the previous
// poll's final item sits in the output register. No clearing pass is needed
// after reset: per-entry valid bits make unwritten entries read as zero.
// Registers: 0x0 first_delay_ms, 0x4 repeat_interval_ms, 0x8
// max_events_per_poll (values above 14 act as 14); write them only while no
// poll is in flight.
module button_autorepeat_events_top #(
  parameter int NUM_BUTTONS = bae_pkg::NumButtonsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bae_poll_if.sink                   poll_i,
  bae_evt_if.source                  evt_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bae_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int EW = 65; // {repeating, hold_start}

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0]                    first_ms_q, rep_ms_q;
  logic [3:0]                     cap_q;
  logic [bae_pkg::DelayTickW-1:0] t_first_q, t_rep_q;
  logic                           cfg_wr;
  logic [1:0]                     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  // Keep the tick-scaled delays next to the ms values so the scan path
  // sees only a subtract and compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_ms_q <= bae_pkg::FirstDelayRst;
      rep_ms_q   <= bae_pkg::RepeatIntvlRst;
      cap_q      <= bae_pkg::MaxEventsRst;
      t_first_q  <= bae_pkg::ms_to_ticks(bae_pkg::FirstDelayRst);
      t_rep_q    <= bae_pkg::ms_to_ticks(bae_pkg::RepeatIntvlRst);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bae_pkg::RegFirstDelay: begin
          first_ms_q <= pwdata[15:0];
          t_first_q  <= bae_pkg::ms_to_ticks(pwdata[15:0]);
        end
        bae_pkg::RegRepeatIntvl: begin
          rep_ms_q <= pwdata[15:0];
          t_rep_q  <= bae_pkg::ms_to_ticks(pwdata[15:0]);
        end
        bae_pkg::RegMaxEvents: cap_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bae_pkg::RegFirstDelay:  prdata = {16'd0, first_ms_q};
      bae_pkg::RegRepeatIntvl: prdata = {16'd0, rep_ms_q};
      bae_pkg::RegMaxEvents:   prdata = {28'd0, cap_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Poll capture and sequencer
  // ---------------------------------------------------------------------
  logic [1:0]             state_q, state_d;
  logic [NUM_BUTTONS-1:0] press_q, held_q;
  logic [63:0]            tick_q;
  logic                   rd_on_q, rd_on_d;
  logic [IW-1:0]          rd_idx_q, rd_idx_d;
  logic                   p_vld_q, p_vld_d;
  logic [IW-1:0]          p_idx_q, p_idx_d;
  logic [3:0]             count_q, count_d;
  logic [NUM_BUTTONS-1:0] emit_q, emit_d;
  logic                   poll_acc;
  logic [63:0]            press_wide, held_wide;

  assign poll_i.ready = (state_q == StIdle);
  assign poll_acc     = poll_i.valid && poll_i.ready;
  assign press_wide   = {{(64 - bae_pkg::MaskW){1'b0}}, poll_i.pressed_now};
  assign held_wide    = {{(64 - bae_pkg::MaskW){1'b0}}, poll_i.held_now};

  // Hold the poll fields for the whole scan.
  always_ff @(posedge clk_i) begin
    if (poll_acc) begin
      press_q <= press_wide[NUM_BUTTONS-1:0];
      held_q  <= held_wide[NUM_BUTTONS-1:0];
      tick_q  <= poll_i.tick_now;
    end
  end

  // ---------------------------------------------------------------------
  // Per-button state memory: read one entry ahead, write back behind
  // ---------------------------------------------------------------------
  logic [EW-1:0]          mem [NUM_BUTTONS];
  logic [EW-1:0]          rdata_q;
  logic [NUM_BUTTONS-1:0] ent_vld_q;
  logic                   rd_en, wr_en;
  logic [EW-1:0]          wdata;

  assign rd_en = (state_q == StScan) && rd_on_q;
  assign wr_en = p_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[p_idx_q] <= wdata;
    if (rd_en) rdata_q <= mem[rd_idx_q];
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (wr_en) begin
      ent_vld_q[p_idx_q] <= 1'b1;
    end
  end

  // Update of the entry read last cycle. Reads and writes of one poll never
  // touch the same entry in flight, so no forwarding is needed.
  logic [63:0] hs_cur, elapsed, hs_new;
  logic        rep_cur, rep_new, fire;
  logic [3:0]  cap_eff;

  assign cap_eff = (cap_q > bae_pkg::ResultLimit) ? bae_pkg::ResultLimit : cap_q;

  always_comb begin
    hs_cur  = ent_vld_q[p_idx_q] ? rdata_q[63:0] : 64'd0;
    rep_cur = ent_vld_q[p_idx_q] ? rdata_q[64]   : 1'b0;
    elapsed = tick_q - hs_cur;
    fire    = 1'b0;
    hs_new  = hs_cur;
    rep_new = rep_cur;
    priority if (press_q[p_idx_q]) begin
      fire    = 1'b1;
      hs_new  = tick_q;
      rep_new = 1'b0;
    end else if (held_q[p_idx_q]) begin
      if (!rep_cur) begin
        if (elapsed >= {{(64 - bae_pkg::DelayTickW){1'b0}}, t_first_q}) begin
          fire    = 1'b1;
          rep_new = 1'b1;
          hs_new  = tick_q;
        end
      end else if (elapsed >= {{(64 - bae_pkg::DelayTickW){1'b0}}, t_rep_q}) begin
        fire   = 1'b1;
        hs_new = tick_q;
      end
    end else begin
      hs_new  = 64'd0;
      rep_new = 1'b0;
    end
    wdata = {rep_new, hs_new};
  end

  // ---------------------------------------------------------------------
  // Event delivery: lowest pending button first
  // ---------------------------------------------------------------------
  logic [NUM_BUTTONS-1:0] low_bit, emit_rest;
  logic [3:0]             low_idx;
  logic                   out_vld_q, out_vld_d, out_load;
  logic [3:0]             out_btn_q, out_btn_d;
  logic                   out_ev_q, out_ev_d, out_last_q, out_last_d;

  always_comb begin
    low_bit   = emit_q & (~emit_q + NUM_BUTTONS'(1));
    emit_rest = emit_q & ~low_bit;
    low_idx   = 4'd0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (low_bit[i]) low_idx = low_idx | 4'(i);
    end
  end

  assign out_load = (state_q == StEmit) && (!out_vld_q || evt_o.ready);

  always_comb begin
    state_d    = state_q;
    rd_on_d    = rd_on_q;
    rd_idx_d   = rd_idx_q;
    p_vld_d    = 1'b0;
    p_idx_d    = p_idx_q;
    count_d    = count_q;
    emit_d     = emit_q;
    out_vld_d  = out_vld_q && !evt_o.ready;
    out_btn_d  = out_btn_q;
    out_ev_d   = out_ev_q;
    out_last_d = out_last_q;
    unique case (state_q)
      StIdle: begin
        if (poll_acc) begin
          rd_on_d  = 1'b1;
          rd_idx_d = '0;
          count_d  = 4'd0;
          emit_d   = '0;
          state_d  = StScan;
        end
      end
      StScan: begin
        if (rd_en) begin
          p_vld_d = 1'b1;
          p_idx_d = rd_idx_q;
          if (rd_idx_q == IW'(NUM_BUTTONS - 1)) rd_on_d = 1'b0;
          else rd_idx_d = rd_idx_q + IW'(1);
        end
        if (p_vld_q) begin
          // Drop events past the cap; state still updates.
          if (fire && (count_q < cap_eff)) begin
            emit_d[p_idx_q] = 1'b1;
            count_d         = count_q + 4'd1;
          end
          if (p_idx_q == IW'(NUM_BUTTONS - 1)) state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          if (emit_q == '0) begin
            out_btn_d  = 4'd0;
            out_ev_d   = 1'b0;
            out_last_d = 1'b1;
            state_d    = StIdle;
          end else begin
            out_btn_d  = low_idx;
            out_ev_d   = 1'b1;
            out_last_d = (emit_rest == '0);
            emit_d     = emit_rest;
            if (emit_rest == '0) state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_on_q   <= 1'b0;
      rd_idx_q  <= '0;
      p_vld_q   <= 1'b0;
      p_idx_q   <= '0;
      count_q   <= 4'd0;
      emit_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_on_q   <= rd_on_d;
      rd_idx_q  <= rd_idx_d;
      p_vld_q   <= p_vld_d;
      p_idx_q   <= p_idx_d;
      count_q   <= count_d;
      emit_q    <= emit_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_btn_q  <= out_btn_d;
    out_ev_q   <= out_ev_d;
    out_last_q <= out_last_d;
  end

  assign evt_o.valid        = out_vld_q;
  assign evt_o.button_event = out_btn_q;
  assign evt_o.event_valid  = out_ev_q;
  assign evt_o.last         = out_last_q;

endmodule

>>> design/bae_chk.sv
// Port-level checker for the button autorepeat event block, bound to the
// top level. Depends on button_autorepeat_events_top.
`timescale 1ns / 1ps

module bae_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       poll_valid,
  input logic       poll_ready,
  input logic       evt_valid,
  input logic       evt_ready,
  input logic [3:0] evt_button,
  input logic       evt_ev,
  input logic       evt_last,
  input logic       pready
);

  // An empty-poll marker always closes its poll.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && !evt_ev |-> evt_last && (evt_button == 4'd0))
    else $error("empty marker without last");

  // A poll is never taken back to back: the scan needs the memory first.
  a_poll_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_valid && poll_ready |=> !poll_ready)
    else $error("poll accepted during scan");

  // A stalled event item holds.
  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt_button) && $stable(evt_ev)
      && $stable(evt_last))
    else $error("event item changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind button_autorepeat_events_top bae_chk u_bae_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .poll_valid (poll_i.valid),
  .poll_ready (poll_i.ready),
  .evt_valid  (evt_o.valid),
  .evt_ready  (evt_o.ready),
  .evt_button (evt_o.button_event),
  .evt_ev     (evt_o.event_valid),
  .evt_last   (evt_o.last),
  .pready     (pready)
);
